// ===== hw/rtl/pms_pkg.sv =====
// Shared widths and a pair helper for the pair merge sorter.
`default_nettype none
package pms_pkg;
   localparam int KEY_W  = 32;
   localparam int PAIR_W = 2 * KEY_W;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [PAIR_W-1:0]       pair_type;

   // The key sits in the low half of a pair, the value in the high half.
   function automatic key_type pair_key(input pair_type p);
      pair_key = p[KEY_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/pair_merge_sorter.sv =====
// Pair merge sorter: loads a list of key/value pairs and streams it back sorted by key.
//
// The req_ channel takes one pair per cycle while the block is loading; req_tlast marks
// the final pair of a list. Pairs beyond MAX_ITEMS are dropped, and every result of that
// list then carries rsp_tuser high. After the final pair the block sorts the stored
// list with a bottom-up stable merge sort over two RAMs used as ping-pong buffers, one
// signed key compare per merged pair. Each pass walks the list once, in these steps per
// pair: read the head of the left run, read the head of the right run, compare and
// write; a setup step comes before each run pair. The single RAM read port is why the
// two heads are read in separate steps. Results then leave on the rsp_ channel in
// ascending key order, equal keys in load order; the next result is not read until the
// current one is taken, and rsp_tlast marks the final one. A stalled receiver simply
// holds the current result in the output register. req_tready is low from the final
// pair until the last result is taken. Synchronous reset empties the list and clears
// the overflow mark; the RAM contents need no clearing, since only entries written for
// the current list are read.
`default_nettype none
module pair_merge_sorter #(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [pms_pkg::PAIR_W-1:0] req_tdata,  // item_key, item_value
   input  wire logic                      req_tlast,  // last_item
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [pms_pkg::PAIR_W-1:0] rsp_tdata,  // out_key, out_value
   output logic                           rsp_tlast,  // out_last
   output logic                           rsp_tuser   // overflowed
);
   import pms_pkg::*;

   localparam int AW    = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITEMS);
   localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

   localparam logic [2:0] ST_LOAD = 3'd0;
   localparam logic [2:0] ST_SEG  = 3'd1;
   localparam logic [2:0] ST_RDA  = 3'd2;
   localparam logic [2:0] ST_RDB  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;
   localparam logic [2:0] ST_ORD  = 3'd5;
   localparam logic [2:0] ST_OCAP = 3'd6;
   localparam logic [2:0] ST_OSHW = 3'd7;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             src_ff, src_in;
   logic [CNT_W-1:0] width_ff, width_in;
   logic [CNT_W-1:0] a_ff, a_in, b_ff, b_in, k_ff, k_in;
   logic [CNT_W-1:0] mid_ff, mid_in, hi_ff, hi_in;
   pair_type         head_ff, head_in;
   pair_type         rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_acc, store_en, take_a;
   logic [CNT_W:0]   sum_mid, sum_hi, width_dbl;
   logic [CNT_W-1:0] k_next;
   logic [AW-1:0]    rd_addr, wr_addr;
   pair_type         wr_data, rd_data0, rd_data1, rd_data, pick;
   logic             we0, we1;

   function automatic logic [CNT_W-1:0] k_next_count(input logic [CNT_W-1:0] c);
      k_next_count = c + ONE_CNT;
   endfunction

   assign req_tready = (state_ff == ST_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign store_en   = req_acc && (count_ff < MAX_CNT);

   assign rd_data   = src_ff ? rd_data1 : rd_data0;
   assign sum_mid   = {1'b0, k_ff} + {1'b0, width_ff};
   assign sum_hi    = {1'b0, k_ff} + ({1'b0, width_ff} << 1);
   assign width_dbl = {1'b0, width_ff} << 1;
   assign k_next    = k_ff + ONE_CNT;

   // Take the left head while it exists and the right run is empty or not smaller.
   assign take_a = (a_ff < mid_ff) &&
                   ((b_ff >= hi_ff) || (pair_key(head_ff) <= pair_key(rd_data)));
   assign pick   = take_a ? head_ff : rd_data;

   always_comb begin
      unique case (state_ff)
         ST_RDA:  rd_addr = a_ff[AW-1:0];
         ST_RDB:  rd_addr = b_ff[AW-1:0];
         default: rd_addr = k_ff[AW-1:0];
      endcase
   end

   assign wr_addr = (state_ff == ST_LOAD) ? count_ff[AW-1:0] : k_ff[AW-1:0];
   assign wr_data = (state_ff == ST_LOAD) ? req_tdata : pick;
   assign we0     = store_en || ((state_ff == ST_CMP) && src_ff);
   assign we1     = (state_ff == ST_CMP) && !src_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_in       = src_ff;
      width_in     = width_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      head_in      = head_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (store_en) begin
                  count_in = k_next_count(count_ff);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_tlast) begin
                  src_in   = 1'b0;
                  width_in = ONE_CNT;
                  k_in     = '0;
                  // A single pair is already sorted.
                  if ((store_en ? k_next_count(count_ff) : count_ff) == ONE_CNT) begin
                     state_in = ST_ORD;
                  end else begin
                     state_in = ST_SEG;
                  end
               end
            end
         end
         ST_SEG: begin
            a_in     = k_ff;
            mid_in   = (sum_mid > {1'b0, count_ff}) ? count_ff : sum_mid[CNT_W-1:0];
            b_in     = (sum_mid > {1'b0, count_ff}) ? count_ff : sum_mid[CNT_W-1:0];
            hi_in    = (sum_hi > {1'b0, count_ff}) ? count_ff : sum_hi[CNT_W-1:0];
            state_in = ST_RDA;
         end
         ST_RDA: begin
            state_in = ST_RDB;
         end
         ST_RDB: begin
            head_in  = rd_data;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (take_a) begin
               a_in = a_ff + ONE_CNT;
            end else begin
               b_in = b_ff + ONE_CNT;
            end
            k_in = k_next;
            if (k_next != hi_ff) begin
               state_in = ST_RDA;
            end else if (hi_ff != count_ff) begin
               state_in = ST_SEG;
            end else begin
               // Pass complete: the written buffer becomes the source.
               src_in = !src_ff;
               k_in   = '0;
               if (width_dbl >= {1'b0, count_ff}) begin
                  state_in = ST_ORD;
               end else begin
                  width_in = width_dbl[CNT_W-1:0];
                  state_in = ST_SEG;
               end
            end
         end
         ST_ORD: begin
            state_in = ST_OCAP;
         end
         ST_OCAP: begin
            rsp_data_in  = rd_data;
            rsp_last_in  = (k_next == count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_OSHW;
         end
         ST_OSHW: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_LOAD;
               end else begin
                  k_in     = k_next;
                  state_in = ST_ORD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         src_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         src_ff       <= src_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      width_ff    <= width_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      k_ff        <= k_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      head_ff     <= head_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   pms_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_ram0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data0)
   );

   pms_ram #(.WIDTH(PAIR_W), .DEPTH(MAX_ITEMS)) u_ram1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data1)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = ovf_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/pms_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module pms_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/pms_checker.sv =====
// Port-level checks for the pair merge sorter, bound to the top level.
`default_nettype none
module pms_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tready,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [pms_pkg::PAIR_W-1:0] rsp_tdata,
   input wire logic                       rsp_tlast,
   input wire logic                       rsp_tuser
);
   import pms_pkg::*;

   logic    in_run_ff;
   key_type prev_key_ff;
   logic    rsp_acc;

   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Tracks the previous key within one sorted list.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff <= 1'b0;
      end else if (rsp_acc) begin
         in_run_ff <= !rsp_tlast;
      end
      if (rsp_acc) begin
         prev_key_ff <= pair_key(rsp_tdata);
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading and output overlap");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && in_run_ff |-> pair_key(rsp_tdata) >= prev_key_ff)
      else $error("results out of key order");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("block not idle after reset");

   a_user: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && in_run_ff |-> rsp_tuser == $past(rsp_tuser))
      else $error("overflow mark changed within a list");
endmodule

bind pair_merge_sorter pms_checker u_pms_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the pair merge sorter: directed and random key/value lists, stable-sort check.
`timescale 1ns / 100ps
module testbench;
   import pms_pkg::*;

   localparam int      CAPACITY    = 64;
   localparam int      ITEM_GOAL   = 330;
   localparam int      STALL_LIMIT = 20000;
   localparam key_type KEY_MIN     = 32'h8000_0000;
   localparam key_type KEY_MAX     = 32'h7fff_ffff;

   typedef struct {
      key_type key;
      key_type value;
   } kv_pair;

   typedef struct {
      key_type key;
      key_type value;
      bit      last;
      bit      dropped;
   } sorted_result;

   // Keeps the list being loaded in stable key order and the sorted results still owed.
   class sort_order_scoreboard;
      kv_pair       loading_list[$];
      bit           list_overflowed;
      sorted_result owed_results[$];
      int           errors;

      function void take_pair(input key_type key, input key_type value, input bit last_pair);
         kv_pair entry;
         sorted_result res;
         int pos;
         entry.key   = key;
         entry.value = value;
         if (loading_list.size() < CAPACITY) begin
            // Insert after every stored pair whose key is not greater, so equal keys keep
            // their load order.
            pos = loading_list.size();
            while (pos > 0 && $signed(loading_list[pos-1].key) > $signed(key))
               pos--;
            loading_list.insert(pos, entry);
         end else begin
            list_overflowed = 1'b1;
         end
         if (last_pair) begin
            foreach (loading_list[i]) begin
               res.key     = loading_list[i].key;
               res.value   = loading_list[i].value;
               res.last    = (i == loading_list.size() - 1);
               res.dropped = list_overflowed;
               owed_results.push_back(res);
            end
            loading_list.delete();
            list_overflowed = 1'b0;
         end
      endfunction

      function void check_sorted_pair(input key_type key, input key_type value,
                                      input bit last, input bit dropped);
         sorted_result exp;
         if (owed_results.size() == 0) begin
            $display("%0t: result key %0d value %0d arrived with nothing expected",
                     $time, key, value);
            errors++;
            return;
         end
         exp = owed_results.pop_front();
         if (key !== exp.key) begin
            $display("%0t: out_key expected %0d, got %0d", $time, exp.key, key);
            errors++;
         end
         if (value !== exp.value) begin
            $display("%0t: out_value expected %0d, got %0d", $time, exp.value, value);
            errors++;
         end
         if (last !== exp.last) begin
            $display("%0t: out_last expected %0b, got %0b", $time, exp.last, last);
            errors++;
         end
         if (dropped !== exp.dropped) begin
            $display("%0t: overflowed expected %0b, got %0b", $time, exp.dropped, dropped);
            errors++;
         end
      endfunction

      function int owed_count();
         return owed_results.size();
      endfunction
   endclass

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [PAIR_W-1:0]   req_tdata  = '0;   // item_key, item_value
   logic                req_tlast  = 1'b0; // last_item
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [PAIR_W-1:0]   rsp_tdata;         // out_key, out_value
   logic                rsp_tlast;         // out_last
   logic                rsp_tuser;         // overflowed

   sort_order_scoreboard board = new;
   int                   items_offered = 0;
   bit                   sender_burst  = 1'b0;
   int                   stalled_cycles = 0;

   pair_merge_sorter #(.MAX_ITEMS(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            board.take_pair(req_tdata[KEY_W-1:0], req_tdata[PAIR_W-1:KEY_W], req_tlast);
         if (rsp_tvalid && rsp_tready)
            board.check_sorted_pair(rsp_tdata[KEY_W-1:0], rsp_tdata[PAIR_W-1:KEY_W],
                                    rsp_tlast, rsp_tuser);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalled_cycles <= 0;
         else
            stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles == STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Full-range keys, small keys that collide so that stability is exercised, and the
   // signed extremes, zero and minus one.
   function automatic key_type random_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 4)
         return key_type'($urandom);
      else if (sel < 7)
         return key_type'($urandom_range(0, 6)) - 3;
      case ($urandom_range(0, 3))
         0: return KEY_MIN;
         1: return KEY_MAX;
         2: return 0;
         default: return -1;
      endcase
   endfunction

   task automatic send_pair(input key_type key, input key_type value, input bit last_pair);
      int gap;
      gap = sender_burst ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {value, key};
      req_tlast  <= last_pair;
      @(posedge clock);
      while (!(req_tvalid && req_tready))
         @(posedge clock);
      items_offered++;
      if (items_offered % 16 == 0)
         sender_burst = ($urandom_range(0, 3) == 0);
   endtask

   task automatic send_list(input key_type keys[$], input key_type values[$]);
      foreach (keys[i])
         send_pair(keys[i], values[i], i == keys.size() - 1);
   endtask

   initial begin : receiver
      int gap;
      int taken;
      bit burst;
      bit held;
      taken = 0;
      burst = 1'b0;
      held  = 1'b0;
      @(negedge reset);
      forever begin
         if (taken == 80 && !held) begin
            // Long hold-off while a list is being returned, so the input side backs up.
            gap  = 500;
            held = 1'b1;
         end else begin
            gap = burst ? 0 : $urandom_range(0, 10);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready))
            @(posedge clock);
         taken++;
         if (taken % 24 == 0)
            burst = ($urandom_range(0, 3) == 0);
      end
   end

   initial begin : stimulus
      key_type keys[$];
      key_type values[$];
      int      list_no;
      int      len;
      int      r;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // A list of one item, at the field extremes.
      keys   = '{KEY_MIN};
      values = '{KEY_MAX};
      send_list(keys, values);
      // Extremes, duplicates and mixed signs in one list.
      keys   = '{KEY_MAX, 0, -1, KEY_MIN, 5, 5, -1, KEY_MAX, 1, KEY_MIN};
      values = '{KEY_MIN, 1, 2, 3, -1, 0, KEY_MAX, 7, 8, 9};
      send_list(keys, values);
      // Two items in descending order.
      keys   = '{3, -3};
      values = '{30, -30};
      send_list(keys, values);
      // All keys equal: load order must be kept.
      keys   = '{7, 7, 7, 7, 7};
      values = '{0, 1, 2, 3, 4};
      send_list(keys, values);
      // Already sorted.
      keys   = '{-100, -2, 0, 100};
      values = '{11, 12, 13, 14};
      send_list(keys, values);

      list_no = 0;
      while (items_offered < ITEM_GOAL) begin
         r = $urandom_range(0, 19);
         if (list_no == 0)
            len = CAPACITY;
         else if (list_no == 1)
            len = CAPACITY + 3;   // overflows, and the final pair itself is dropped
         else if (r == 0)
            len = $urandom_range(17, CAPACITY);
         else if (r == 1)
            len = CAPACITY + 1;
         else
            len = $urandom_range(1, 16);
         keys.delete();
         values.delete();
         repeat (len) begin
            keys.push_back(random_key());
            values.push_back(key_type'($urandom));
         end
         send_list(keys, values);
         list_no++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (board.owed_count() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (board.errors == 0 && board.owed_count() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
